### rtl/core/adhi_pkg.sv
// ----------------------------------------------------------------------------
// adhi_pkg
// Shared types and constants for the archive directory hash index unit.
// ----------------------------------------------------------------------------
package adhi_pkg;

    localparam int TABLE_BITS   = 10;
    localparam int TABLE_SIZE   = 1 << TABLE_BITS;
    localparam logic [31:0] TABLE_BASE   = 32'(4 + 4 * TABLE_SIZE);
    localparam logic [31:0] HEADER_BYTES = 32'd12;
    localparam logic [31:0] ENTRY_FIXED  = 32'd12;
    localparam logic [15:0] NAME_MAX_LEN = 16'hFFFF;

    // bucket store entry: valid flag on top of the offset word
    localparam int RAM_WIDTH = 33;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_NAME   = 3'd1,
        OP_FINISH = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_CLOSE    = 2'd2,
        ST_BUCKET   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  name_byte;
        logic [30:0] data_length;
        logic [9:0]  bucket_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  bucket;
        logic        bucket_filled;
        logic [31:0] table_word;
        logic [31:0] data_offset;
        logic [31:0] total_size;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input transaction this cycle
        logic clr_en;    // clearing pass writes one bucket
        logic resolve;   // finish the held item and load the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic clr_last;  // clearing pass is at its last bucket
    } sts_t;

endpackage

### rtl/core/archive_directory_hash_index_unit.sv
// ----------------------------------------------------------------------------
// archive_directory_hash_index_unit
// Hashed directory index builder: name hashing, bucket store, offset counters.
// ----------------------------------------------------------------------------
// Sequence: a name byte, a clear or an unused op code is only accepted. A
// close is accepted, then resolved; a finish or a bucket read goes through
// accept, bucket RAM read and resolve, and the resolve waits while the output
// register holds a result that m_ready has not taken. After reset and after
// every clear transaction the bucket RAM is swept by a clearing pass over all
// 2^TABLE_BITS buckets (1024 by default), one bucket per cycle, during which
// s_ready stays low. A finished result sits in the output register while the next input transaction is taken.
module archive_directory_hash_index_unit
    import adhi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    cmd_t cmd;
    sts_t sts;

    adhi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_item.op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    adhi_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### rtl/core/adhi_ram.sv
// ----------------------------------------------------------------------------
// adhi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/adhi_ctrl.sv
// ----------------------------------------------------------------------------
// adhi_ctrl
// Sequencer: clearing pass, item accept, bucket lookup and result hand-off.
// ----------------------------------------------------------------------------
module adhi_ctrl
    import adhi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [2:0] s_op,
    output logic       s_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        cmd.accept  = s_valid && s_ready_reg;
        cmd.clr_en  = (state_reg == S_CLEAR);
        cmd.resolve = (state_reg == S_RESOLVE) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd.accept) begin
                    case (s_op)
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_FINISH: state_next = S_LOOKUP;
                        OP_READ:   state_next = S_LOOKUP;
                        OP_CLOSE:  state_next = S_RESOLVE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == S_IDLE);
        end
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == S_IDLE))
        else $error("s_ready high outside idle");

    a_lookup_then_resolve: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOKUP) |=> (state_reg == S_RESOLVE))
        else $error("lookup not followed by resolve");

endmodule

### rtl/core/adhi_datapath.sv
// ----------------------------------------------------------------------------
// adhi_datapath
// Hash and counter registers, bucket store, and the output register.
// ----------------------------------------------------------------------------
module adhi_datapath
    import adhi_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_item,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [TABLE_BITS-1:0] hash_reg, hash_next;
    logic [15:0]           nlen_reg, nlen_next;
    logic [31:0]           dpos_reg, dpos_next;
    logic [31:0]           used_reg, used_next;
    logic [2:0]            op_reg;
    logic [TABLE_BITS-1:0] cur_bucket_reg;
    logic [15:0]           cur_len_reg;
    logic [30:0]           cur_dlen_reg;
    logic [TABLE_BITS-1:0] clr_cnt_reg;
    logic                  m_valid_reg;
    out_item_t             m_item_reg, m_item_next;

    logic                  ram_we;
    logic [TABLE_BITS-1:0] ram_waddr;
    logic [RAM_WIDTH-1:0]  ram_wdata;
    logic [RAM_WIDTH-1:0]  ram_rdata;
    logic                  rd_filled;
    logic [31:0]           rd_word;
    logic [31:0]           new_word;
    logic                  commit;
    logic [TABLE_BITS-1:0] rot;

    assign rd_filled = ram_rdata[RAM_WIDTH-1];
    assign rd_word   = ram_rdata[31:0];
    assign new_word  = TABLE_BASE + used_reg;
    assign commit    = cmd.resolve && (op_reg == OP_FINISH) && !rd_filled;
    assign rot       = {hash_reg[TABLE_BITS-2:0], hash_reg[TABLE_BITS-1]};

    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.clr_last = (clr_cnt_reg == {TABLE_BITS{1'b1}});

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // clearing pass writes invalid entries; a commit fills one bucket
    always_comb begin
        ram_we    = cmd.clr_en || commit;
        ram_waddr = cmd.clr_en ? clr_cnt_reg : cur_bucket_reg;
        ram_wdata = cmd.clr_en ? '0 : {1'b1, new_word};
    end

    adhi_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (TABLE_SIZE)
    ) u_bucket_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_bucket_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        hash_next = hash_reg;
        nlen_next = nlen_reg;
        dpos_next = dpos_reg;
        used_next = used_reg;
        if (cmd.accept) begin
            case (s_item.op)
                OP_CLEAR: begin
                    hash_next = '0;
                    nlen_next = '0;
                    dpos_next = HEADER_BYTES;
                    used_next = '0;
                end
                OP_NAME: begin
                    if (s_item.name_byte != 8'd0) begin
                        hash_next = rot + TABLE_BITS'(s_item.name_byte);
                        if (nlen_reg != NAME_MAX_LEN) begin
                            nlen_next = nlen_reg + 16'd1;
                        end
                    end
                end
                OP_FINISH: begin
                    hash_next = '0;
                    nlen_next = '0;
                end
                default: begin
                end
            endcase
        end
        if (commit) begin
            dpos_next = dpos_reg + {1'b0, cur_dlen_reg};
            used_next = used_reg + ENTRY_FIXED + {16'd0, cur_len_reg}
                      + {29'd0, 3'd4 - {1'b0, cur_len_reg[1:0]}};
        end
    end

    always_comb begin
        m_item_next = m_item_reg;
        case (op_reg)
            OP_FINISH: begin
                m_item_next.status        = rd_filled ? ST_REJECTED : ST_ACCEPTED;
                m_item_next.bucket        = 10'(cur_bucket_reg);
                m_item_next.bucket_filled = 1'b1;
                m_item_next.table_word    = rd_filled ? rd_word : new_word;
                m_item_next.data_offset   = dpos_reg;
                m_item_next.total_size    = '0;
            end
            OP_CLOSE: begin
                m_item_next.status        = ST_CLOSE;
                m_item_next.bucket        = '0;
                m_item_next.bucket_filled = 1'b0;
                m_item_next.table_word    = '0;
                m_item_next.data_offset   = dpos_reg;
                m_item_next.total_size    = dpos_reg + TABLE_BASE + used_reg;
            end
            OP_READ: begin
                m_item_next.status        = ST_BUCKET;
                m_item_next.bucket        = 10'(cur_bucket_reg);
                m_item_next.bucket_filled = rd_filled;
                m_item_next.table_word    = rd_filled ? rd_word : 32'd0;
                m_item_next.data_offset   = '0;
                m_item_next.total_size    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= '0;
            nlen_reg    <= '0;
            dpos_reg    <= HEADER_BYTES;
            used_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            nlen_reg <= nlen_next;
            dpos_reg <= dpos_next;
            used_reg <= used_next;
            if (cmd.clr_en) begin
                clr_cnt_reg <= clr_cnt_reg + TABLE_BITS'(1);
            end
            if (cmd.resolve) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item hold and output payload: no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg <= s_item.op;
            if (s_item.op == OP_FINISH) begin
                cur_bucket_reg <= hash_reg;
                cur_len_reg    <= nlen_reg;
                cur_dlen_reg   <= s_item.data_length;
            end else if (s_item.op == OP_READ) begin
                cur_bucket_reg <= TABLE_BITS'(s_item.bucket_index);
            end
        end
        if (cmd.resolve) begin
            m_item_reg <= m_item_next;
        end
    end

    a_resolve_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.resolve |-> sts.out_free)
        else $error("result loaded over an untaken result");

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr_en && (cmd.resolve || cmd.accept)))
        else $error("clearing pass overlaps item processing");

    a_resolve_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.resolve |=> m_valid_reg)
        else $error("resolved item did not raise m_valid");

endmodule

### tb/archive_directory_hash_index_unit_test.sv
// ----------------------------------------------------------------------------
// archive_directory_hash_index_unit_test
// Self-checking bench for the directory hash index unit. A table of directed
// transactions covers empty names, duplicates, counter wrap, ignored bytes and
// ops, clears and reads of empty and filled buckets. Then random entries,
// reads and closes run with random idling on both channels. Every result is
// checked against a predictor or, for typed directed rows, a planned result.
// ----------------------------------------------------------------------------
module archive_directory_hash_index_unit_test;
    import adhi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned IDLE_PCT      = 20;
    localparam int unsigned DRAIN_CYCLES  = 16;
    localparam logic [30:0] LEN_MAX       = '1;
    localparam logic [9:0]  LAST_BUCKET   = 10'(TABLE_SIZE - 1);
    // op codes the block ignores
    localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  OP_RSVD_MID   = 3'd6;
    localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t reply;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // predictor state
    logic [TABLE_BITS-1:0] idx_hash;
    logic [15:0]           idx_name_len;
    logic [31:0]           idx_data_pos;
    logic [31:0]           idx_table_used;
    bit                    idx_filled [TABLE_SIZE];
    logic [31:0]           idx_word   [TABLE_SIZE];

    out_item_t     replies_due [$];
    plan_row_t     directed_plan [$];
    logic [31:0]   name_seeds [$];
    int unsigned   name_lens [$];
    logic [9:0]    used_buckets [$];
    int unsigned   random_items;
    int unsigned   fail_count;
    int unsigned   cycle_count;
    bit            steady;

    archive_directory_hash_index_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    function automatic void index_clear();
        idx_hash       = '0;
        idx_name_len   = '0;
        idx_data_pos   = HEADER_BYTES;
        idx_table_used = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            idx_filled[i] = 1'b0;
            idx_word[i]   = '0;
        end
    endfunction

    // Apply one accepted transaction; returns 1 when it produces a result.
    function automatic bit index_update(input in_item_t it, output out_item_t reply);
        logic [TABLE_BITS-1:0] b;
        logic [15:0]           nl;
        reply = '0;
        case (it.op)
            OP_CLEAR: begin
                index_clear();
                return 1'b0;
            end
            OP_NAME: begin
                if (it.name_byte != 8'h00) begin
                    idx_hash = {idx_hash[TABLE_BITS-2:0], idx_hash[TABLE_BITS-1]}
                               + TABLE_BITS'(it.name_byte);
                    if (idx_name_len != NAME_MAX_LEN)
                        idx_name_len = idx_name_len + 16'd1;
                end
                return 1'b0;
            end
            OP_FINISH: begin
                b = idx_hash;
                nl = idx_name_len;
                idx_hash = '0;
                idx_name_len = '0;
                reply.bucket        = 10'(b);
                reply.bucket_filled = 1'b1;
                reply.data_offset   = idx_data_pos;
                if (idx_filled[b]) begin
                    reply.status     = ST_REJECTED;
                    reply.table_word = idx_word[b];
                end else begin
                    reply.status     = ST_ACCEPTED;
                    reply.table_word = TABLE_BASE + idx_table_used;
                    idx_filled[b]    = 1'b1;
                    idx_word[b]      = reply.table_word;
                    idx_data_pos     = idx_data_pos + {1'b0, it.data_length};
                    // entry record: fixed part, name, then 1..4 bytes of padding
                    idx_table_used   = idx_table_used + ENTRY_FIXED + 32'(nl)
                                       + (32'd4 - 32'(nl[1:0]));
                end
                return 1'b1;
            end
            OP_CLOSE: begin
                reply.status      = ST_CLOSE;
                reply.data_offset = idx_data_pos;
                reply.total_size  = idx_data_pos + TABLE_BASE + idx_table_used;
                return 1'b1;
            end
            OP_READ: begin
                b = it.bucket_index[TABLE_BITS-1:0];
                reply.status        = ST_BUCKET;
                reply.bucket        = 10'(b);
                reply.bucket_filled = idx_filled[b];
                reply.table_word    = idx_filled[b] ? idx_word[b] : 32'd0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic in_item_t item_of(input op_t op, input logic [7:0] nb,
                                         input logic [30:0] dl, input logic [9:0] bi);
        in_item_t it;
        it.op           = op;
        it.name_byte    = nb;
        it.data_length  = dl;
        it.bucket_index = bi;
        return it;
    endfunction

    function automatic out_item_t reply_of(input status_t st, input logic [9:0] bk,
                                           input logic f, input logic [31:0] w,
                                           input logic [31:0] d, input logic [31:0] t);
        out_item_t r;
        r.status        = st;
        r.bucket        = bk;
        r.bucket_filled = f;
        r.table_word    = w;
        r.data_offset   = d;
        r.total_size    = t;
        return r;
    endfunction

    // all fields random, the op fixed
    function automatic in_item_t rand_item(input op_t op);
        return item_of(op, 8'($urandom), 31'($urandom), 10'($urandom));
    endfunction

    function automatic logic [7:0] name_char(input logic [31:0] seed, input int unsigned pos);
        logic [31:0] x;
        x = seed ^ (pos * 32'h9E37_79B9);
        x = x ^ (x >> 15);
        x = x * 32'h2C1B_3C6D;
        x = x ^ (x >> 12);
        return (x[7:0] == 8'h00) ? 8'h2E : x[7:0];
    endfunction

    function automatic logic [30:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return LEN_MAX;
            1, 2, 3: return 31'($urandom);
            default: return 31'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic plan(input in_item_t it, input bit typed, input out_item_t reply);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.reply = reply;
        directed_plan.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t reply);
        out_item_t predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (index_update(it, predicted))
            replies_due.push_back(typed ? reply : predicted);
    endtask

    task automatic send_counted(input in_item_t it);
        send_item(it, 1'b0, '0);
        random_items++;
    endtask

    // read of a random or recently used bucket, or a close report
    task automatic random_probe();
        in_item_t it;
        if ($urandom_range(0, 1) == 1) begin
            it = rand_item(OP_READ);
            if (used_buckets.size() != 0 && $urandom_range(0, 1) == 1)
                it.bucket_index = used_buckets[$urandom_range(0, used_buckets.size() - 1)];
        end else begin
            it = rand_item(OP_CLOSE);
        end
        send_counted(it);
    endtask

    // one name plus finish; a quarter of names repeat an earlier one
    task automatic random_entry();
        logic [31:0] seed;
        int unsigned len;
        int unsigned k;
        in_item_t    it;
        if (name_seeds.size() != 0 && $urandom_range(0, 3) == 0) begin
            k    = $urandom_range(0, name_seeds.size() - 1);
            seed = name_seeds[k];
            len  = name_lens[k];
        end else begin
            seed = $urandom;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
            name_seeds.push_back(seed);
            name_lens.push_back(len);
        end
        for (int unsigned p = 0; p < len; p++) begin
            if ($urandom_range(0, 19) == 0) begin
                it = rand_item(OP_NAME);
                it.name_byte = 8'h00;
                send_item(it, 1'b0, '0);
            end
            if ($urandom_range(0, 29) == 0)
                random_probe();
            it = rand_item(OP_NAME);
            it.name_byte = name_char(seed, p);
            send_counted(it);
        end
        // broken sequence: clear in the middle of a name
        if ($urandom_range(0, 39) == 0)
            send_counted(rand_item(OP_CLEAR));
        used_buckets.push_back(10'(idx_hash));
        it = rand_item(OP_FINISH);
        it.data_length = pick_length();
        send_counted(it);
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("result with none pending, status %0d bucket %h",
                                          m_item.status, m_item.bucket));
            end else begin
                want = replies_due.pop_front();
                check_field("status", 32'(m_item.status), 32'(want.status));
                check_field("bucket", 32'(m_item.bucket), 32'(want.bucket));
                check_field("bucket_filled", 32'(m_item.bucket_filled),
                            32'(want.bucket_filled));
                check_field("table_word", m_item.table_word, want.table_word);
                check_field("data_offset", m_item.data_offset, want.data_offset);
                check_field("total_size", m_item.total_size, want.total_size);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout, %0d results still pending", replies_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        m_ready      = 1'b0;
        steady       = 1'b0;
        fail_count   = 0;
        cycle_count  = 0;
        random_items = 0;
        index_clear();

        // directed transactions: typed results where the value is plain
        plan(item_of(OP_CLOSE, 8'h00, '0, '0), 1'b1,
             reply_of(ST_CLOSE, '0, 1'b0, '0, HEADER_BYTES, HEADER_BYTES + TABLE_BASE));
        plan(item_of(OP_READ, 8'hFF, LEN_MAX, '0), 1'b1,
             reply_of(ST_BUCKET, '0, 1'b0, '0, '0, '0));
        plan(item_of(OP_READ, 8'h00, '0, LAST_BUCKET), 1'b1,
             reply_of(ST_BUCKET, LAST_BUCKET, 1'b0, '0, '0, '0));
        // empty name lands in bucket 0
        plan(item_of(OP_FINISH, 8'hFF, '0, LAST_BUCKET), 1'b1,
             reply_of(ST_ACCEPTED, '0, 1'b1, TABLE_BASE, HEADER_BYTES, '0));
        plan(item_of(OP_FINISH, 8'h00, LEN_MAX, '0), 1'b1,
             reply_of(ST_REJECTED, '0, 1'b1, TABLE_BASE, HEADER_BYTES, '0));
        plan(item_of(OP_READ, 8'h00, '0, '0), 1'b1,
             reply_of(ST_BUCKET, '0, 1'b1, TABLE_BASE, '0, '0));
        plan(item_of(OP_CLOSE, 8'hFF, LEN_MAX, LAST_BUCKET), 1'b0, '0);
        // nul byte is dropped, then a name whose hash wraps past the top bit
        plan(item_of(OP_NAME, 8'h00, LEN_MAX, LAST_BUCKET), 1'b0, '0);
        plan(item_of(OP_NAME, 8'hFF, '0, '0), 1'b0, '0);
        plan(item_of(OP_NAME, 8'h01, '0, '0), 1'b0, '0);
        plan(item_of(OP_NAME, 8'h80, '0, '0), 1'b0, '0);
        plan(item_of(OP_FINISH, 8'h00, LEN_MAX, '0), 1'b0, '0);
        // second max-length entry wraps the data position
        plan(item_of(OP_NAME, 8'hFF, '0, '0), 1'b0, '0);
        plan(item_of(OP_FINISH, 8'h00, LEN_MAX, '0), 1'b0, '0);
        plan(item_of(OP_CLOSE, 8'h00, '0, '0), 1'b0, '0);
        plan(item_of(OP_READ, 8'h00, '0, 10'h07E), 1'b0, '0);
        plan(item_of(OP_READ, 8'h00, '0, 10'h0FF), 1'b0, '0);
        plan(item_of(op_t'(OP_RSVD_FIRST), 8'hFF, LEN_MAX, LAST_BUCKET), 1'b0, '0);
        plan(item_of(op_t'(OP_RSVD_MID), 8'h5A, '0, '0), 1'b0, '0);
        plan(item_of(op_t'(OP_RSVD_LAST), 8'hA5, LEN_MAX, LAST_BUCKET), 1'b0, '0);
        plan(item_of(OP_CLEAR, 8'hFF, LEN_MAX, LAST_BUCKET), 1'b0, '0);
        plan(item_of(OP_CLOSE, 8'h00, '0, '0), 1'b1,
             reply_of(ST_CLOSE, '0, 1'b0, '0, HEADER_BYTES, HEADER_BYTES + TABLE_BASE));
        plan(item_of(OP_READ, 8'h00, '0, 10'h0FF), 1'b1,
             reply_of(ST_BUCKET, 10'h0FF, 1'b0, '0, '0, '0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i])
            send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].reply);

        while (random_items < RANDOM_ITEMS) begin
            steady = (random_items >= 150 && random_items < 260);
            case ($urandom_range(0, 99)) inside
                [0:54]:  random_entry();
                [55:79]: random_probe();
                [80:87]: begin
                    it = rand_item(OP_FINISH);
                    it.data_length = pick_length();
                    send_counted(it);
                end
                [88:94]: begin
                    it = rand_item(OP_NAME);
                    it.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
                    send_item(it, 1'b0, '0);
                end
                [95:96]: send_counted(rand_item(OP_CLEAR));
                default: begin
                    // stray byte that folds into the next name
                    it = rand_item(OP_NAME);
                    send_item(it, 1'b0, '0);
                    if (it.name_byte != 8'h00)
                        random_items++;
                end
            endcase
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
